@@ rtl/usc_pkg.sv @@
package usc_pkg;

  // Event codes carried on in_operation
  typedef enum logic [2:0] {
    OP_BUTTON      = 3'd0,
    OP_OUT_ON      = 3'd1,
    OP_OUT_OFF     = 3'd2,
    OP_CHG_ON      = 3'd3,
    OP_CHG_OFF     = 3'd4,
    OP_ALERT       = 3'd5,
    OP_READ_TOTALS = 3'd6,
    OP_READ_ALERT  = 3'd7
  } usc_op_t;

  // Default number of alert counter slots
  localparam int USC_ALERT_SLOTS = 32;

  // floor(x / 60) for any 32-bit x is (x * ceil(2^37 / 60)) >> 37
  localparam logic [31:0] USC_DIV60_MAGIC = 32'h8888_8889;
  localparam int          USC_DIV60_SHIFT = 37;

  // Divide a 32-bit seconds value by sixty with a reciprocal multiply
  function automatic logic [31:0] usc_div60(input logic [31:0] x);
    logic [63:0] prod;
    prod = {32'd0, x} * {32'd0, USC_DIV60_MAGIC};
    return 32'(prod >> USC_DIV60_SHIFT);
  endfunction

  // Index of the highest set bit; zero when no bit is set
  function automatic logic [4:0] usc_top_bit(input logic [31:0] x);
    logic [4:0] hi;
    hi = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        hi = 5'(i);
      end
    end
    return hi;
  endfunction

endpackage

@@ rtl/usage_statistics_counters.sv @@
// Usage statistics counters. Each accepted event updates the button count, the output and
// charging on-time totals (in minutes) and the per-slot alert counters, and produces one
// result with the running totals, the system minutes and, for a read alert event, the
// count of the requested slot. The block takes one event every clock cycle while in_stall
// is low; an event passes through the input register, the interval stage and the result
// register, and out_stall holds the stages in place while a result waits. The alert counters
// are a small register array with one read and one write port; they read as zero after
// reset, with no clearing pass. cfg_wr_data loads the base minutes and is to be written
// while no event is in flight.
module usage_statistics_counters
  import usc_pkg::*;
#(
  parameter int ALERT_SLOTS = USC_ALERT_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // event channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_now_seconds,
  input  logic [31:0] in_alert_mask,
  input  logic [4:0]  in_alert_slot,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_button_presses,
  output logic [31:0] out_output_minutes,
  output logic [31:0] out_charge_minutes,
  output logic [31:0] out_system_minutes,
  output logic [31:0] out_alert_count
);

  localparam int         SLOT_W     = (ALERT_SLOTS > 1) ? $clog2(ALERT_SLOTS) : 1;
  localparam logic [5:0] SLOT_LIMIT = 6'(ALERT_SLOTS);

  // Interval bookkeeping for one on-time accumulator
  typedef struct packed {
    logic        add_en;  // an open interval contributes to the total
    logic        commit;  // fold the interval into the stored total
    logic        borrow;  // clock went backwards
    logic [31:0] diff;    // elapsed seconds
  } span_t;

  function automatic span_t open_span(input logic turn_on, input logic turn_off,
                                      input logic act, input logic [31:0] start,
                                      input logic [31:0] now);
    logic [31:0] s;
    span_t       sp;
    s         = (turn_on && !act) ? now : start;
    sp.add_en = turn_on | act;
    sp.commit = turn_off;
    sp.borrow = now < s;
    sp.diff   = now - s;
    return sp;
  endfunction

  function automatic logic [31:0] at_least_one(input logic [31:0] q);
    return (q == 32'd0) ? 32'd1 : q;
  endfunction

  function automatic logic [31:0] span_minutes(input span_t sp);
    logic [31:0] m;
    m = sp.borrow ? 32'd1 : at_least_one(usc_div60(sp.diff));
    return sp.add_en ? m : 32'd0;
  endfunction

  // Configuration and accumulated state
  logic [31:0]            base_r;
  logic [31:0]            press_r;
  logic [31:0]            out_total_r;
  logic [31:0]            out_start_r;
  logic                   out_act_r;
  logic [31:0]            chg_total_r;
  logic [31:0]            chg_start_r;
  logic                   chg_act_r;
  logic [31:0]            alert_mem [ALERT_SLOTS];
  logic [ALERT_SLOTS-1:0] alert_vld_r;

  // Input register
  logic        a_valid_r;
  usc_op_t     a_op_r;
  logic [31:0] a_now_r;
  logic [31:0] a_mask_r;
  logic [4:0]  a_slot_r;

  // Interval stage
  logic              b_valid_r;
  usc_op_t           b_op_r;
  logic [31:0]       b_now_r;
  span_t             b_out_span_r;
  span_t             b_chg_span_r;
  logic              b_wr_en_r;
  logic              b_rd_en_r;
  logic [SLOT_W-1:0] b_addr_r;
  logic [31:0]       b_cnt_r;

  // Result register
  logic        c_valid_r;
  logic [31:0] c_button_r;
  logic [31:0] c_output_r;
  logic [31:0] c_charge_r;
  logic [31:0] c_system_r;
  logic [31:0] c_alert_r;

  // Pipeline flow control
  logic c_free;
  logic b_free;
  logic a_free;
  logic b_adv;
  logic a_adv;
  logic in_xfer;

  assign c_free   = !c_valid_r || !out_stall;
  assign b_adv    = b_valid_r && c_free;
  assign b_free   = !b_valid_r || c_free;
  assign a_adv    = a_valid_r && b_free;
  assign a_free   = !a_valid_r || b_free;
  assign in_stall = !a_free;
  assign in_xfer  = in_valid && a_free;

  // Interval stage inputs
  span_t             a_out_span;
  span_t             a_chg_span;
  logic [4:0]        a_hi;
  logic [4:0]        a_raddr5;
  logic              a_in_range;
  logic              a_wr_en;
  logic              a_rd_en;
  logic [SLOT_W-1:0] a_addr;
  logic              a_fwd;

  assign a_out_span = open_span(a_op_r == OP_OUT_ON, a_op_r == OP_OUT_OFF, out_act_r,
                                out_start_r, a_now_r);
  assign a_chg_span = open_span(a_op_r == OP_CHG_ON, a_op_r == OP_CHG_OFF, chg_act_r,
                                chg_start_r, a_now_r);
  assign a_hi       = usc_top_bit(a_mask_r);
  assign a_raddr5   = (a_op_r == OP_ALERT) ? a_hi : a_slot_r;
  assign a_in_range = {1'b0, a_raddr5} < SLOT_LIMIT;
  assign a_wr_en    = (a_op_r == OP_ALERT) && (a_mask_r != 32'd0) && a_in_range;
  assign a_rd_en    = (a_op_r == OP_READ_ALERT) && a_in_range;
  assign a_addr     = a_raddr5[SLOT_W-1:0];
  // The slot being incremented in the interval stage is written at the same edge
  assign a_fwd      = b_valid_r && b_wr_en_r && (b_addr_r == a_addr);

  // Result stage arithmetic
  logic [31:0] b_out_sum;
  logic [31:0] b_chg_sum;
  logic [31:0] b_sys;
  logic [31:0] press_nxt;

  assign b_out_sum = out_total_r + span_minutes(b_out_span_r);
  assign b_chg_sum = chg_total_r + span_minutes(b_chg_span_r);
  assign b_sys     = base_r + at_least_one(usc_div60(b_now_r));
  assign press_nxt = press_r + ((b_op_r == OP_BUTTON) ? 32'd1 : 32'd0);

  // Hold the base minutes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_wr_en) begin
      base_r <= cfg_wr_data;
    end
  end

  // Capture an event transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_free) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_op_r   <= usc_op_t'(in_operation);
      a_now_r  <= in_now_seconds;
      a_mask_r <= in_alert_mask;
      a_slot_r <= in_alert_slot;
    end
  end

  // Track active flags and start stamps as events advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_act_r   <= 1'b0;
      out_start_r <= '0;
      chg_act_r   <= 1'b0;
      chg_start_r <= '0;
    end else if (a_adv) begin
      case (a_op_r)
        OP_OUT_ON: begin
          if (!out_act_r) begin
            out_act_r   <= 1'b1;
            out_start_r <= a_now_r;
          end
        end
        OP_OUT_OFF: begin
          out_act_r <= 1'b0;
        end
        OP_CHG_ON: begin
          if (!chg_act_r) begin
            chg_act_r   <= 1'b1;
            chg_start_r <= a_now_r;
          end
        end
        OP_CHG_OFF: begin
          chg_act_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Advance into the interval stage and read the alert slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_free) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_op_r       <= a_op_r;
      b_now_r      <= a_now_r;
      b_out_span_r <= a_out_span;
      b_chg_span_r <= a_chg_span;
      b_wr_en_r    <= a_wr_en;
      b_rd_en_r    <= a_rd_en;
      b_addr_r     <= a_addr;
      if (a_fwd) begin
        b_cnt_r <= b_cnt_r + 32'd1;
      end else if (alert_vld_r[a_addr]) begin
        b_cnt_r <= alert_mem[a_addr];
      end else begin
        b_cnt_r <= '0;
      end
    end
  end

  // Write back the incremented alert slot
  always_ff @(posedge clk) begin
    if (b_adv && b_wr_en_r) begin
      alert_mem[b_addr_r] <= b_cnt_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alert_vld_r <= '0;
    end else if (b_adv && b_wr_en_r) begin
      alert_vld_r[b_addr_r] <= 1'b1;
    end
  end

  // Fold closed intervals and button presses into the totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r     <= '0;
      out_total_r <= '0;
      chg_total_r <= '0;
    end else if (b_adv) begin
      press_r <= press_nxt;
      if (b_out_span_r.commit) begin
        out_total_r <= b_out_sum;
      end
      if (b_chg_span_r.commit) begin
        chg_total_r <= b_chg_sum;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (c_free) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      c_button_r <= press_nxt;
      c_output_r <= b_out_sum;
      c_charge_r <= b_chg_sum;
      c_system_r <= b_sys;
      c_alert_r  <= b_rd_en_r ? b_cnt_r : 32'd0;
    end
  end

  assign out_valid          = c_valid_r;
  assign out_button_presses = c_button_r;
  assign out_output_minutes = c_output_r;
  assign out_charge_minutes = c_charge_r;
  assign out_system_minutes = c_system_r;
  assign out_alert_count    = c_alert_r;

`ifndef SYNTHESIS
  // An off event always leaves its accumulator inactive
  assert property (@(posedge clk) disable iff (!rst_n)
    a_adv && (a_op_r == OP_OUT_OFF) |=> !out_act_r)
    else $error("output accumulator still active after off event");

  assert property (@(posedge clk) disable iff (!rst_n)
    a_adv && (a_op_r == OP_CHG_OFF) |=> !chg_act_r)
    else $error("charge accumulator still active after off event");

  // A button event raises the press count by exactly one
  assert property (@(posedge clk) disable iff (!rst_n)
    b_adv && (b_op_r == OP_BUTTON) |=> press_r == $past(press_r) + 32'd1)
    else $error("press count did not advance by one");

  // Only an in-range read alert event reports a slot count
  assert property (@(posedge clk) disable iff (!rst_n)
    b_adv && !b_rd_en_r |=> out_alert_count == 32'd0)
    else $error("alert count reported without a slot read");
`endif

endmodule

@@ sim/usage_statistics_counters_test.sv @@
module usage_statistics_counters_test;
  import usc_pkg::*;

  localparam int          SLOTS         = USC_ALERT_SLOTS;
  localparam logic [31:0] SIXTY         = 32'd60;
  localparam int          IDLE_PCT      = 33;
  localparam int          STUCK_LIMIT   = 1000;
  localparam int          SETTLE_CYCLES = 8;

  typedef struct {
    logic [31:0] presses;
    logic [31:0] output_min;
    logic [31:0] charge_min;
    logic [31:0] system_min;
    logic [31:0] alert_cnt;
  } usage_totals_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_operation;
  logic [31:0] in_now_seconds;
  logic [31:0] in_alert_mask;
  logic [4:0]  in_alert_slot;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_button_presses;
  logic [31:0] out_output_minutes;
  logic [31:0] out_charge_minutes;
  logic [31:0] out_system_minutes;
  logic [31:0] out_alert_count;

  // Counter state as the block should hold it
  logic [31:0] minutes_base;
  logic [31:0] press_count;
  logic [31:0] out_total;
  logic [31:0] out_start;
  logic        out_on;
  logic [31:0] chg_total;
  logic [31:0] chg_start;
  logic        chg_on;
  logic [31:0] alert_tally [SLOTS];

  usage_totals_t pending_totals[$];
  int            errors;
  int            sent_count;
  int            checked_count;
  int            stuck_cycles;
  bit            calm;

  usage_statistics_counters dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_now_seconds     (in_now_seconds),
    .in_alert_mask      (in_alert_mask),
    .in_alert_slot      (in_alert_slot),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_button_presses (out_button_presses),
    .out_output_minutes (out_output_minutes),
    .out_charge_minutes (out_charge_minutes),
    .out_system_minutes (out_system_minutes),
    .out_alert_count    (out_alert_count)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Minutes of an open interval: at least one, exactly one if the clock went back
  function automatic logic [31:0] elapsed_minutes(logic [31:0] start, logic [31:0] now);
    logic [31:0] m;
    if (now < start) return 32'd1;
    m = (now - start) / SIXTY;
    return (m == 32'd0) ? 32'd1 : m;
  endfunction

  function automatic logic [31:0] open_total(logic [31:0] total, logic on,
                                             logic [31:0] start, logic [31:0] now);
    return on ? total + elapsed_minutes(start, now) : total;
  endfunction

  // Apply one event to the counter state and return the totals it reports
  function automatic usage_totals_t account_event(usc_op_t op, logic [31:0] now,
                                                  logic [31:0] mask, logic [4:0] slot);
    usage_totals_t t;
    int            hi;
    logic [31:0]   sys;
    t.alert_cnt = '0;
    case (op)
      OP_BUTTON: press_count = press_count + 32'd1;
      OP_OUT_ON: begin
        if (!out_on) begin
          out_on    = 1'b1;
          out_start = now;
        end
      end
      OP_OUT_OFF: begin
        out_total = open_total(out_total, out_on, out_start, now);
        out_on    = 1'b0;
      end
      OP_CHG_ON: begin
        if (!chg_on) begin
          chg_on    = 1'b1;
          chg_start = now;
        end
      end
      OP_CHG_OFF: begin
        chg_total = open_total(chg_total, chg_on, chg_start, now);
        chg_on    = 1'b0;
      end
      OP_ALERT: begin
        if (mask != 32'd0) begin
          hi = 31;
          while (!mask[hi]) hi--;
          if (hi < SLOTS) alert_tally[hi] = alert_tally[hi] + 32'd1;
        end
      end
      OP_READ_ALERT: begin
        if (slot < SLOTS) t.alert_cnt = alert_tally[slot];
      end
      default: ;
    endcase
    sys = now / SIXTY;
    if (sys == 32'd0) sys = 32'd1;
    t.presses    = press_count;
    t.output_min = open_total(out_total, out_on, out_start, now);
    t.charge_min = open_total(chg_total, chg_on, chg_start, now);
    t.system_min = sys + minutes_base;
    return t;
  endfunction

  // Drive one event from a falling edge and hold it until the transfer
  task automatic send_event(usc_op_t op, logic [31:0] now, logic [31:0] mask,
                            logic [4:0] slot);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_now_seconds <= now;
    in_alert_mask  <= mask;
    in_alert_slot  <= slot;
    do @(posedge clk); while (in_stall);
    pending_totals.push_back(account_event(op, now, mask, slot));
    sent_count++;
    @(negedge clk);
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_totals.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Load the base minutes while the block is idle
  task automatic load_minutes_base(logic [31:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    minutes_base = value;
  endtask

  task automatic test_reset_totals();
    send_event(OP_READ_TOTALS, 32'd0, 32'd0, 5'd0);
    send_event(OP_READ_ALERT, 32'd59, 32'hFFFF_FFFF, 5'd0);
    send_event(OP_READ_ALERT, 32'd60, 32'd0, 5'd31);
    send_event(OP_READ_TOTALS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
    send_event(OP_BUTTON, 32'd0, 32'd0, 5'd0);
    send_event(OP_BUTTON, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
  endtask

  task automatic test_on_time();
    // output: repeated on keeps the first stamp, short interval counts one minute
    send_event(OP_OUT_ON, 32'd100, 32'd0, 5'd0);
    send_event(OP_OUT_ON, 32'd500, 32'd0, 5'd0);
    send_event(OP_READ_TOTALS, 32'd130, 32'd0, 5'd0);
    send_event(OP_OUT_OFF, 32'd700, 32'd0, 5'd0);
    send_event(OP_OUT_OFF, 32'd800, 32'd0, 5'd0);
    // charge: clock running backwards, then the widest interval
    send_event(OP_CHG_ON, 32'd1000, 32'd0, 5'd0);
    send_event(OP_READ_TOTALS, 32'd999, 32'd0, 5'd0);
    send_event(OP_CHG_OFF, 32'd999, 32'd0, 5'd0);
    send_event(OP_CHG_ON, 32'd0, 32'd0, 5'd0);
    send_event(OP_CHG_OFF, 32'hFFFF_FFFF, 32'd0, 5'd0);
    send_event(OP_CHG_OFF, 32'd5, 32'd0, 5'd0);
  endtask

  task automatic test_alert_slots();
    send_event(OP_ALERT, 32'd10, 32'd0, 5'd0);
    send_event(OP_ALERT, 32'd10, 32'd1, 5'd0);
    send_event(OP_ALERT, 32'd10, 32'h8000_0000, 5'd0);
    send_event(OP_ALERT, 32'd10, 32'hFFFF_FFFF, 5'd0);
    send_event(OP_ALERT, 32'd10, 32'h0000_0300, 5'd0);
    send_event(OP_READ_ALERT, 32'd10, 32'd0, 5'd0);
    send_event(OP_READ_ALERT, 32'd10, 32'd0, 5'd31);
    send_event(OP_READ_ALERT, 32'd10, 32'd0, 5'd9);
  endtask

  task automatic test_base_wrap();
    load_minutes_base(32'hFFFF_FFFF);
    send_event(OP_READ_TOTALS, 32'd0, 32'd0, 5'd0);
    send_event(OP_READ_TOTALS, 32'hFFFF_FFFF, 32'd0, 5'd0);
  endtask

  // Pile up wide intervals on both channels until the minute totals wrap
  task automatic test_minute_wrap();
    repeat (62) begin
      send_event(OP_OUT_ON, $urandom_range(1000), $urandom, 5'($urandom_range(31)));
      send_event(OP_CHG_ON, $urandom_range(1000), $urandom, 5'($urandom_range(31)));
      send_event(OP_OUT_OFF, 32'hFFFF_FFFF - $urandom_range(1000), $urandom,
                 5'($urandom_range(31)));
      send_event(OP_CHG_OFF, 32'hFFFF_FFFF - $urandom_range(1000), $urandom,
                 5'($urandom_range(31)));
    end
  endtask

  // Random event stream on a mostly advancing clock
  task automatic test_random_usage(int count);
    logic [31:0] clock_now;
    logic [31:0] mask;
    int          pick;
    clock_now = $urandom;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 80) clock_now = clock_now + $urandom_range(300);
      else if (pick < 90) clock_now = clock_now + $urandom;
      else if (pick < 96) clock_now = clock_now - $urandom_range(1, 5000);
      else clock_now = $urandom;
      case ($urandom_range(7))
        0: mask = 32'd0;
        1, 2, 3: mask = ($urandom | 32'h8000_0000) >> $urandom_range(31);
        default: mask = $urandom;
      endcase
      send_event(usc_op_t'($urandom_range(7)), clock_now, mask, 5'($urandom_range(31)));
    end
  endtask

  // Stall the result side at random, except in a calm stretch
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Check each result transfer against the oldest expectation
  task automatic check_field(string label, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    usage_totals_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_totals.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, got %h %h %h %h %h",
                 $time, out_button_presses, out_output_minutes, out_charge_minutes,
                 out_system_minutes, out_alert_count);
      end else begin
        want = pending_totals.pop_front();
        check_field("button_presses", want.presses, out_button_presses);
        check_field("output_minutes", want.output_min, out_output_minutes);
        check_field("charge_minutes", want.charge_min, out_charge_minutes);
        check_field("system_minutes", want.system_min, out_system_minutes);
        check_field("alert_count", want.alert_cnt, out_alert_count);
        checked_count++;
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, STUCK_LIMIT, pending_totals.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_operation   = OP_BUTTON;
    in_now_seconds = '0;
    in_alert_mask  = '0;
    in_alert_slot  = '0;
    out_stall      = 1'b0;
    calm           = 1'b0;
    errors         = 0;
    sent_count     = 0;
    checked_count  = 0;
    stuck_cycles   = 0;
    minutes_base   = '0;
    press_count    = '0;
    out_total      = '0;
    out_start      = '0;
    out_on         = 1'b0;
    chg_total      = '0;
    chg_start      = '0;
    chg_on         = 1'b0;
    foreach (alert_tally[i]) alert_tally[i] = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_totals();
    test_on_time();
    test_alert_slots();
    test_base_wrap();
    load_minutes_base(32'd0);
    test_minute_wrap();
    test_random_usage(170);
    load_minutes_base($urandom);
    calm = 1'b1;
    test_random_usage(170);
    calm = 1'b0;
    load_minutes_base(32'hFFFF_FFFF - $urandom_range(100000));
    test_random_usage(170);
    drain();

    $display("Sent %0d events and checked %0d results over four base-minute settings,",
             sent_count, checked_count);
    $display("with on/off intervals, clock steps back, minute wrap and all alert slots.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
